FILE: hdl/sbpc_pkg.sv
// ----------------------------------------------------------------------------
// sbpc_pkg - shared types and constants of the blind position controller
// Mode codes, register map, coil table lookup and divider constants.
// ----------------------------------------------------------------------------
package sbpc_pkg;

   // Motion modes as reported on the result channel
   typedef enum logic [2:0] {
      MODE_IDLE_OPEN  = 3'd0,
      MODE_IDLE_CLOSE = 3'd1,
      MODE_OPEN       = 3'd2,
      MODE_CLOSE      = 3'd3,
      MODE_MOVE_TO    = 3'd4,
      MODE_CALIB      = 3'd5
   } mode_type;

   // Register map: index is byte address divided by four
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic        REG_STEP_DELAY  = 1'b0;
   localparam logic        REG_PHASE_TABLE = 1'b1;

   // Register reset values
   localparam logic [15:0] STEP_DELAY_RESET  = 16'd2;
   localparam logic [31:0] PHASE_TABLE_RESET = 32'h98C4_5E31;

   // Field widths
   localparam int unsigned TICK_W    = 16;
   localparam int unsigned PCT_W     = 7;
   localparam int unsigned POS_W     = 32;
   localparam int unsigned COIL_W    = 4;
   localparam int unsigned PHASE_W   = 3;

   // Pending command: top bit flags a command not yet taken
   localparam logic [7:0] CMD_FRESH = 8'h80;
   localparam logic [7:0] CMD_PCT_MASK = 8'h7F;

   // Full travel is split into hundredths before scaling by percent
   localparam logic [7:0] TRAVEL_DIVISOR = 8'd100;

   // Hundredth by reciprocal multiply: exact floor(x / 100) for any 32-bit x
   localparam logic [31:0] HUNDREDTH_RECIP = 32'h51EB_851F;
   localparam int unsigned HUNDREDTH_SHIFT = 37;

   // Phase index offsets (modulo eight)
   localparam logic [2:0] PHASE_FWD  = 3'd1;
   localparam logic [2:0] PHASE_BACK = 3'd7;
   localparam logic [2:0] PHASE_UNDO_FWD  = 3'd6;
   localparam logic [2:0] PHASE_UNDO_BACK = 3'd2;

   // Pick the coil nibble for one phase out of the packed table
   function automatic logic [COIL_W-1:0] pattern_of(input logic [31:0] tbl,
                                                   input logic [PHASE_W-1:0] ph);
      logic [COIL_W-1:0] nib;
      nib = tbl[{ph, 2'b00} +: COIL_W];
      return nib;
   endfunction

endpackage

FILE: hdl/sbpc_req_if.sv
// ----------------------------------------------------------------------------
// sbpc_req_if - poll tick channel
// One beat carries a tick time, button and limit state and an optional command.
// ----------------------------------------------------------------------------
interface sbpc_req_if;
   logic                          valid;
   logic                          ready;
   logic [sbpc_pkg::TICK_W-1:0]   now_ticks;
   logic                          click;
   logic                          limit_hit;
   logic                          command_valid;
   logic [sbpc_pkg::PCT_W-1:0]    command_percent;

   modport source (
      output valid, now_ticks, click, limit_hit, command_valid, command_percent,
      input  ready
   );

   modport sink (
      input  valid, now_ticks, click, limit_hit, command_valid, command_percent,
      output ready
   );
endinterface

FILE: hdl/sbpc_rsp_if.sv
// ----------------------------------------------------------------------------
// sbpc_rsp_if - status channel
// One beat per poll tick: coil pattern, position, stop report and mode.
// ----------------------------------------------------------------------------
interface sbpc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sbpc_pkg::COIL_W-1:0]   coil_drive;
   logic [sbpc_pkg::POS_W-1:0]    position;
   logic                          report_valid;
   logic [2:0]                    mode;

   modport source (
      output valid, coil_drive, position, report_valid, mode,
      input  ready
   );

   modport sink (
      input  valid, coil_drive, position, report_valid, mode,
      output ready
   );
endinterface

FILE: hdl/stepper_blind_position_controller.sv
// ----------------------------------------------------------------------------
// stepper_blind_position_controller - stepper motor blind controller
// Mode machine, half-step phase sequencing and percent positioning.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one poll tick per beat (tick time, click, limit switch,
//   optional move-to command). rsp_chan returns exactly one status beat per
//   poll: coil pattern, step position, stop report flag and mode.
//   csr_* is an APB-style port: step_delay at 0x0, phase_table at 0x4.
//   Write registers only while no poll is in flight.
// Sequencing:
//   A poll is latched as it is taken in S_IDLE and executed in S_EXEC, which
//   commits it once the output register is free. A poll that starts a move-to
//   command first passes S_DIV, which takes a hundredth of full travel by
//   reciprocal multiply, and S_MUL, which scales it by the percent, both on
//   one shared 32 by 32 multiplier.
//   req_chan.ready is high only while the sequencer waits for a poll.
// Reset:
//   Synchronous, active high. Mode idle-open, all counts zero; the first poll
//   enters calibration, which starts on a click and runs to the limit switch.
// Stall:
//   The result sits in an output register; a finished poll waits for that
//   register to drain before it commits, and no new poll is taken meanwhile.
// ----------------------------------------------------------------------------
module stepper_blind_position_controller (
   input  logic                                clock,
   input  logic                                reset,
   sbpc_req_if.sink                            req_chan,
   sbpc_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sbpc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [sbpc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sbpc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_MUL,
      S_EXEC
   } seq_state_type;

   seq_state_type                  state_ff;

   // Configuration registers
   logic [sbpc_pkg::TICK_W-1:0]    step_delay_ff;
   logic [31:0]                    phase_table_ff;

   // Controller state
   sbpc_pkg::mode_type             mode_ff;
   logic [sbpc_pkg::PHASE_W-1:0]   phase_ff;
   logic [sbpc_pkg::POS_W-1:0]     pos_ff;
   logic [sbpc_pkg::POS_W-1:0]     full_ff;
   logic [sbpc_pkg::POS_W-1:0]     target_ff;
   logic [sbpc_pkg::TICK_W-1:0]    last_ff;
   logic [7:0]                     pending_ff;
   logic [sbpc_pkg::COIL_W-1:0]    coil_ff;
   logic                           cal_ff;

   // Latched poll
   logic [sbpc_pkg::TICK_W-1:0]    now_ff;
   logic                           click_ff;
   logic                           limit_ff;

   // Multiplier operand: full travel, then its hundredth
   logic [sbpc_pkg::POS_W-1:0]     dvd_ff;

   // Output register
   logic                           rsp_valid_ff;
   logic [sbpc_pkg::COIL_W-1:0]    rsp_coil_ff;
   logic [sbpc_pkg::POS_W-1:0]     rsp_pos_ff;
   logic                           rsp_report_ff;
   logic [2:0]                     rsp_mode_ff;

   // Next values of one executed poll
   sbpc_pkg::mode_type             mode_in;
   logic [sbpc_pkg::PHASE_W-1:0]   phase_in;
   logic [sbpc_pkg::POS_W-1:0]     pos_in;
   logic [sbpc_pkg::POS_W-1:0]     full_in;
   logic [sbpc_pkg::POS_W-1:0]     target_in;
   logic [sbpc_pkg::TICK_W-1:0]    last_in;
   logic [7:0]                     pending_in;
   logic [sbpc_pkg::COIL_W-1:0]    coil_in;
   logic                           cal_in;
   logic                           report_in;

   logic                           req_beat;
   logic                           csr_write;
   logic                           out_free;
   logic                           commit;
   logic [7:0]                     pend_load;
   sbpc_pkg::mode_type             mode_load;
   logic                           fresh;
   logic                           delay_ok;
   logic                           cal_run;
   logic [sbpc_pkg::COIL_W-1:0]    cur_pattern;
   logic [sbpc_pkg::POS_W-1:0]     mul_b;
   logic [2*sbpc_pkg::POS_W-1:0]   mul_prod;

   // Handshakes
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_beat       = req_chan.valid && req_chan.ready;
   assign csr_write      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready     = 1'b1;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign commit         = (state_ff == S_EXEC) && out_free;

   // Register readback
   always_comb begin
      unique case (csr_paddr[2])
         sbpc_pkg::REG_STEP_DELAY:  csr_prdata = {16'd0, step_delay_ff};
         sbpc_pkg::REG_PHASE_TABLE: csr_prdata = phase_table_ff;
         default:                   csr_prdata = '0;
      endcase
   end

   // Command load and zero-target check done as the poll is taken
   assign pend_load = req_chan.command_valid ?
                      (sbpc_pkg::CMD_FRESH | {1'b0, req_chan.command_percent}) : pending_ff;
   assign mode_load = (target_ff == '0) ? sbpc_pkg::MODE_CALIB : mode_ff;

   // Shared unit: reciprocal of 100 first, then the percent
   assign mul_b    = (state_ff == S_DIV) ? sbpc_pkg::HUNDREDTH_RECIP :
                     {{(sbpc_pkg::POS_W - sbpc_pkg::PCT_W){1'b0}},
                      pending_ff[sbpc_pkg::PCT_W-1:0]};
   assign mul_prod = dvd_ff * mul_b;

   // Per-poll conditions
   assign fresh       = pending_ff[7];
   assign delay_ok    = (now_ff - last_ff) >= step_delay_ff;
   assign cal_run     = cal_ff || click_ff;
   assign cur_pattern = sbpc_pkg::pattern_of(phase_table_ff, phase_ff);

   // Mode machine step for the latched poll
   always_comb begin
      mode_in    = mode_ff;
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      full_in    = full_ff;
      target_in  = target_ff;
      last_in    = last_ff;
      pending_in = pending_ff;
      coil_in    = coil_ff;
      cal_in     = cal_ff;
      report_in  = 1'b0;
      unique case (mode_ff)
         sbpc_pkg::MODE_IDLE_OPEN, sbpc_pkg::MODE_IDLE_CLOSE: begin
            if (click_ff || fresh) begin
               if (pending_ff != '0) begin
                  mode_in = sbpc_pkg::MODE_MOVE_TO;
               end else if (mode_ff == sbpc_pkg::MODE_IDLE_OPEN) begin
                  mode_in = sbpc_pkg::MODE_OPEN;
               end else begin
                  mode_in = sbpc_pkg::MODE_CLOSE;
               end
            end
         end
         sbpc_pkg::MODE_OPEN: begin
            // step toward the open end, then test the stop conditions
            if (delay_ok) begin
               pos_in   = pos_ff - 1'b1;
               coil_in  = cur_pattern;
               phase_in = phase_ff + sbpc_pkg::PHASE_FWD;
               last_in  = now_ff;
            end
            if (click_ff || limit_ff || (pos_in == '0) || fresh) begin
               if (limit_ff) begin
                  pos_in = '0;
               end
               mode_in   = (pending_ff != '0) ? sbpc_pkg::MODE_MOVE_TO
                                              : sbpc_pkg::MODE_IDLE_CLOSE;
               phase_in  = phase_in + sbpc_pkg::PHASE_UNDO_FWD;
               coil_in   = '0;
               report_in = 1'b1;
            end
         end
         sbpc_pkg::MODE_CLOSE: begin
            // step toward the closed end, stop at the target, on a click or on a new command
            if (delay_ok) begin
               pos_in   = pos_ff + 1'b1;
               coil_in  = cur_pattern;
               phase_in = phase_ff + sbpc_pkg::PHASE_BACK;
               last_in  = now_ff;
            end
            if (click_ff || (pos_in >= target_ff) || fresh) begin
               mode_in   = (pending_ff != '0) ? sbpc_pkg::MODE_MOVE_TO
                                              : sbpc_pkg::MODE_IDLE_OPEN;
               phase_in  = phase_in + sbpc_pkg::PHASE_UNDO_BACK;
               coil_in   = '0;
               report_in = 1'b1;
            end
         end
         sbpc_pkg::MODE_MOVE_TO: begin
            // target_ff already holds the scaled target on this path
            if (fresh && !click_ff) begin
               pending_in = pending_ff & sbpc_pkg::CMD_PCT_MASK;
               if (pos_ff > target_ff) begin
                  mode_in = sbpc_pkg::MODE_OPEN;
               end else if (pos_ff < target_ff) begin
                  mode_in = sbpc_pkg::MODE_CLOSE;
               end else begin
                  target_in = full_ff;
                  mode_in   = sbpc_pkg::MODE_IDLE_OPEN;
               end
            end else begin
               pending_in = '0;
               target_in  = full_ff;
               mode_in    = sbpc_pkg::MODE_IDLE_OPEN;
               coil_in    = '0;
            end
         end
         sbpc_pkg::MODE_CALIB: begin
            // a click arms the run; count steps until the limit switch
            cal_in = cal_run;
            if (cal_run) begin
               if (limit_ff) begin
                  full_in   = pos_ff;
                  target_in = pos_ff;
                  pos_in    = '0;
                  mode_in   = sbpc_pkg::MODE_IDLE_CLOSE;
                  phase_in  = phase_ff + sbpc_pkg::PHASE_UNDO_FWD;
                  coil_in   = '0;
                  cal_in    = 1'b0;
               end else if (delay_ok) begin
                  pos_in   = pos_ff + 1'b1;
                  coil_in  = cur_pattern;
                  phase_in = phase_ff + sbpc_pkg::PHASE_FWD;
                  last_in  = now_ff;
               end
            end
         end
         default: begin
            coil_in = '0;
         end
      endcase
   end

   // Sequencer, state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         step_delay_ff  <= sbpc_pkg::STEP_DELAY_RESET;
         phase_table_ff <= sbpc_pkg::PHASE_TABLE_RESET;
         mode_ff        <= sbpc_pkg::MODE_IDLE_OPEN;
         phase_ff       <= '0;
         pos_ff         <= '0;
         full_ff        <= '0;
         target_ff      <= '0;
         last_ff        <= '0;
         pending_ff     <= '0;
         coil_ff        <= '0;
         cal_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // configuration writes
         if (csr_write) begin
            unique case (csr_paddr[2])
               sbpc_pkg::REG_STEP_DELAY:  step_delay_ff  <= csr_pwdata[15:0];
               sbpc_pkg::REG_PHASE_TABLE: phase_table_ff <= csr_pwdata;
               default: ;
            endcase
         end

         // drop the result once taken, unless a new beat replaces it
         if (rsp_valid_ff && rsp_chan.ready && !commit) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_beat) begin
                  now_ff     <= req_chan.now_ticks;
                  click_ff   <= req_chan.click;
                  limit_ff   <= req_chan.limit_hit;
                  pending_ff <= pend_load;
                  mode_ff    <= mode_load;
                  dvd_ff     <= full_ff;
                  if ((mode_load == sbpc_pkg::MODE_MOVE_TO) && pend_load[7] &&
                      !req_chan.click) begin
                     state_ff <= S_DIV;
                  end else begin
                     state_ff <= S_EXEC;
                  end
               end
            end
            S_DIV: begin
               // hundredth of full travel from the high product bits
               dvd_ff   <= sbpc_pkg::POS_W'(mul_prod >> sbpc_pkg::HUNDREDTH_SHIFT);
               state_ff <= S_MUL;
            end
            S_MUL: begin
               // hundredth times percent, truncated to the position width
               target_ff <= mul_prod[sbpc_pkg::POS_W-1:0];
               state_ff  <= S_EXEC;
            end
            S_EXEC: begin
               // commit only when the output register can take the beat
               if (out_free) begin
                  mode_ff       <= mode_in;
                  phase_ff      <= phase_in;
                  pos_ff        <= pos_in;
                  full_ff       <= full_in;
                  target_ff     <= target_in;
                  last_ff       <= last_in;
                  pending_ff    <= pending_in;
                  coil_ff       <= coil_in;
                  cal_ff        <= cal_in;
                  rsp_valid_ff  <= 1'b1;
                  rsp_coil_ff   <= coil_in;
                  rsp_pos_ff    <= pos_in;
                  rsp_report_ff <= report_in;
                  rsp_mode_ff   <= mode_in;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Result channel
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.coil_drive   = rsp_coil_ff;
   assign rsp_chan.position     = rsp_pos_ff;
   assign rsp_chan.report_valid = rsp_report_ff;
   assign rsp_chan.mode         = rsp_mode_ff;

   // A stop report always leaves the coils off
   a_report_coil_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_report_ff |-> rsp_coil_ff == '0)
      else $error("stop report with coils energized");

   // A stop report only ends in idle or move-to
   a_report_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_report_ff |->
         (rsp_mode_ff == sbpc_pkg::MODE_IDLE_OPEN) ||
         (rsp_mode_ff == sbpc_pkg::MODE_IDLE_CLOSE) ||
         (rsp_mode_ff == sbpc_pkg::MODE_MOVE_TO))
      else $error("stop report in a moving mode");

   // A running calibration keeps the controller in calibration
   a_cal_mode: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) && cal_ff |-> mode_ff == sbpc_pkg::MODE_CALIB)
      else $error("calibration flag set outside calibration");

   // The hundredth step always hands over to the percent scaling
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |=> state_ff == S_MUL)
      else $error("hundredth step did not hand over to the scaling");

endmodule

FILE: tb/tb_stepper_blind_position_controller.sv
// ----------------------------------------------------------------------------
// tb_stepper_blind_position_controller - testbench of the blind controller
// Drives poll ticks into the block, predicts every status beat with a
// behavioral model of the mode machine and compares field by field. Runs a
// directed corner sequence, then random polls under several step delays and
// coil tables, with random gaps on the poll channel and stalls on the status channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_stepper_blind_position_controller;

   typedef struct {
      logic [sbpc_pkg::TICK_W-1:0] now_ticks;
      logic                        click;
      logic                        limit_hit;
      logic                        command_valid;
      logic [sbpc_pkg::PCT_W-1:0]  command_percent;
   } poll_type;

   typedef struct {
      logic [sbpc_pkg::COIL_W-1:0] coil_drive;
      logic [sbpc_pkg::POS_W-1:0]  position;
      logic                        report_valid;
      logic [2:0]                  mode;
   } status_type;

   logic clock = 1'b0;
   logic reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [sbpc_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [sbpc_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [sbpc_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   sbpc_req_if req_bus ();
   sbpc_rsp_if rsp_bus ();

   stepper_blind_position_controller u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow registers and controller state of the predictor
   logic [15:0]                    cfg_step_delay;
   logic [31:0]                    cfg_phase_table;
   sbpc_pkg::mode_type             cur_mode;
   logic [sbpc_pkg::PHASE_W-1:0]   phase_idx;
   logic [sbpc_pkg::POS_W-1:0]     step_pos;
   logic [sbpc_pkg::POS_W-1:0]     full_travel;
   logic [sbpc_pkg::POS_W-1:0]     target_steps;
   logic [sbpc_pkg::TICK_W-1:0]    last_step;
   logic [7:0]                     pending_cmd;
   logic [sbpc_pkg::COIL_W-1:0]    coil;
   bit                             cal_running;

   status_type  due_status[$];
   int unsigned mismatches = 0;

   // Stimulus shaping
   int unsigned                 gap_pct;
   int unsigned                 stall_pct;
   int unsigned                 stall_left = 0;
   logic [sbpc_pkg::TICK_W-1:0] tick_now = '0;
   int unsigned                 cal_ticks = 0;
   int unsigned                 cal_goal = 0;

   function automatic void reset_blind();
      cfg_step_delay  = sbpc_pkg::STEP_DELAY_RESET;
      cfg_phase_table = sbpc_pkg::PHASE_TABLE_RESET;
      cur_mode        = sbpc_pkg::MODE_IDLE_OPEN;
      phase_idx       = '0;
      step_pos        = '0;
      full_travel     = '0;
      target_steps    = '0;
      last_step       = '0;
      pending_cmd     = '0;
      coil            = '0;
      cal_running     = 1'b0;
   endfunction

   function automatic bit delay_elapsed(input logic [sbpc_pkg::TICK_W-1:0] now);
      logic [sbpc_pkg::TICK_W-1:0] since;
      since = now - last_step;
      return since >= cfg_step_delay;
   endfunction

   // Drive the present phase onto the coils, then move the phase index
   function automatic void take_phase(input logic [sbpc_pkg::TICK_W-1:0] now,
                                      input logic [sbpc_pkg::PHASE_W-1:0] delta);
      coil      = sbpc_pkg::COIL_W'(cfg_phase_table >> (4 * phase_idx));
      phase_idx = phase_idx + delta;
      last_step = now;
   endfunction

   // Advance the controller by one poll and return its status beat
   function automatic status_type advance_blind(input poll_type p);
      status_type s;
      logic       fresh;
      logic       report;
      report = 1'b0;
      if (p.command_valid)
         pending_cmd = sbpc_pkg::CMD_FRESH | {1'b0, p.command_percent};
      if (target_steps == '0)
         cur_mode = sbpc_pkg::MODE_CALIB;
      fresh = (pending_cmd & sbpc_pkg::CMD_FRESH) != '0;

      case (cur_mode)
         sbpc_pkg::MODE_IDLE_OPEN, sbpc_pkg::MODE_IDLE_CLOSE: begin
            if (p.click || fresh) begin
               if (pending_cmd != '0)
                  cur_mode = sbpc_pkg::MODE_MOVE_TO;
               else
                  cur_mode = (cur_mode == sbpc_pkg::MODE_IDLE_OPEN) ?
                             sbpc_pkg::MODE_OPEN : sbpc_pkg::MODE_CLOSE;
            end
         end
         sbpc_pkg::MODE_OPEN: begin
            if (delay_elapsed(p.now_ticks)) begin
               step_pos = step_pos - 1;
               take_phase(p.now_ticks, sbpc_pkg::PHASE_FWD);
            end
            if (p.click || p.limit_hit || step_pos == '0 || fresh) begin
               if (p.limit_hit)
                  step_pos = '0;
               cur_mode  = (pending_cmd != '0) ? sbpc_pkg::MODE_MOVE_TO
                                               : sbpc_pkg::MODE_IDLE_CLOSE;
               phase_idx = phase_idx + sbpc_pkg::PHASE_UNDO_FWD;
               coil      = '0;
               report    = 1'b1;
            end
         end
         sbpc_pkg::MODE_CLOSE: begin
            if (delay_elapsed(p.now_ticks)) begin
               step_pos = step_pos + 1;
               take_phase(p.now_ticks, sbpc_pkg::PHASE_BACK);
            end
            if (p.click || step_pos >= target_steps || fresh) begin
               cur_mode  = (pending_cmd != '0) ? sbpc_pkg::MODE_MOVE_TO
                                               : sbpc_pkg::MODE_IDLE_OPEN;
               phase_idx = phase_idx + sbpc_pkg::PHASE_UNDO_BACK;
               coil      = '0;
               report    = 1'b1;
            end
         end
         sbpc_pkg::MODE_MOVE_TO: begin
            if (fresh && !p.click) begin
               pending_cmd  = pending_cmd & sbpc_pkg::CMD_PCT_MASK;
               target_steps = (full_travel / sbpc_pkg::POS_W'(sbpc_pkg::TRAVEL_DIVISOR)) *
                              sbpc_pkg::POS_W'(pending_cmd);
               if (step_pos > target_steps) begin
                  cur_mode = sbpc_pkg::MODE_OPEN;
               end else if (step_pos < target_steps) begin
                  cur_mode = sbpc_pkg::MODE_CLOSE;
               end else begin
                  target_steps = full_travel;
                  cur_mode     = sbpc_pkg::MODE_IDLE_OPEN;
               end
            end else begin
               // stale or cancelled command: fall back to idle at full travel
               pending_cmd  = '0;
               target_steps = full_travel;
               cur_mode     = sbpc_pkg::MODE_IDLE_OPEN;
               coil         = '0;
            end
         end
         sbpc_pkg::MODE_CALIB: begin
            if (!cal_running && p.click)
               cal_running = 1'b1;
            if (cal_running) begin
               if (p.limit_hit) begin
                  full_travel  = step_pos;
                  target_steps = step_pos;
                  step_pos     = '0;
                  cur_mode     = sbpc_pkg::MODE_IDLE_CLOSE;
                  phase_idx    = phase_idx + sbpc_pkg::PHASE_UNDO_FWD;
                  coil         = '0;
                  cal_running  = 1'b0;
               end else if (delay_elapsed(p.now_ticks)) begin
                  step_pos = step_pos + 1;
                  take_phase(p.now_ticks, sbpc_pkg::PHASE_FWD);
               end
            end
         end
         default: begin
            coil = '0;
         end
      endcase

      s.coil_drive   = coil;
      s.position     = step_pos;
      s.report_valid = report;
      s.mode         = cur_mode;
      return s;
   endfunction

   function automatic poll_type make_poll(input logic [sbpc_pkg::TICK_W-1:0] now,
                                          input logic click,
                                          input logic limit, input logic cmd,
                                          input logic [sbpc_pkg::PCT_W-1:0] pct);
      poll_type p;
      p.now_ticks       = now;
      p.click           = click;
      p.limit_hit       = limit;
      p.command_valid   = cmd;
      p.command_percent = pct;
      return p;
   endfunction

   // Random poll, steered by the predicted state so calibration completes
   // and moves run for a while before something stops them
   function automatic poll_type next_poll();
      poll_type p;
      bit       calibrating;
      p.click           = 1'b0;
      p.limit_hit       = 1'b0;
      p.command_valid   = 1'b0;
      p.command_percent = $urandom_range(0, 127);
      case ($urandom_range(0, 15))
         0:       tick_now = $urandom_range(0, 65535);
         1, 2, 3: tick_now = last_step + cfg_step_delay;
         4:       tick_now = last_step + cfg_step_delay - 16'd1;
         default: tick_now = tick_now + $urandom_range(0, 3);
      endcase
      p.now_ticks = tick_now;
      calibrating = (cur_mode == sbpc_pkg::MODE_CALIB) || (target_steps == '0);

      if (calibrating && !cal_running) begin
         p.click = ($urandom_range(0, 2) == 0);
         if (p.click) begin
            cal_ticks = 0;
            cal_goal  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12)
                                                   : $urandom_range(100, 220);
         end
         p.limit_hit     = ($urandom_range(0, 5) == 0);
         p.command_valid = ($urandom_range(0, 9) == 0);
      end else if (calibrating) begin
         cal_ticks++;
         p.limit_hit     = (cal_ticks >= cal_goal);
         p.click         = ($urandom_range(0, 9) == 0);
         p.command_valid = ($urandom_range(0, 9) == 0);
      end else begin
         p.click         = ($urandom_range(0, 13) == 0);
         p.command_valid = ($urandom_range(0, 9) == 0);
         if (p.command_valid && $urandom_range(0, 5) != 0)
            p.command_percent = $urandom_range(0, 100);
         if (cur_mode == sbpc_pkg::MODE_OPEN && step_pos < 4)
            p.limit_hit = ($urandom_range(0, 1) == 0);
         else
            p.limit_hit = ($urandom_range(0, 39) == 0);
      end
      return p;
   endfunction

   // Send one poll beat, optionally after an idle burst, and queue its status
   task automatic send_poll(input poll_type p);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.now_ticks       <= p.now_ticks;
      req_bus.click           <= p.click;
      req_bus.limit_hit       <= p.limit_hit;
      req_bus.command_valid   <= p.command_valid;
      req_bus.command_percent <= p.command_percent;
      do @(posedge clock); while (!req_bus.ready);
      due_status.push_back(advance_blind(p));
   endtask

   task automatic csr_write(input logic reg_sel, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_sel == sbpc_pkg::REG_STEP_DELAY)
         cfg_step_delay = value[15:0];
      else
         cfg_phase_table = value;
      @(posedge clock);
   endtask

   // Drain all outstanding status beats, then load both registers
   task automatic configure(input logic [15:0] delay, input logic [31:0] coil_table);
      req_bus.valid <= 1'b0;
      while (due_status.size() != 0) @(posedge clock);
      csr_write(sbpc_pkg::REG_STEP_DELAY, {16'd0, delay});
      csr_write(sbpc_pkg::REG_PHASE_TABLE, coil_table);
   endtask

   task automatic run_random_polls(input int unsigned count);
      repeat (count) send_poll(next_poll());
   endtask

   // Calibration, stale command, position wrap, oversize percent, zero target
   task automatic test_directed_corners();
      configure(16'd1, sbpc_pkg::PHASE_TABLE_RESET);
      gap_pct   = 0;
      stall_pct = 0;
      send_poll(make_poll(16'd1,  0, 0, 0, 7'd0));    // enter calibration
      send_poll(make_poll(16'd2,  1, 0, 1, 7'd100));  // start run, command held
      send_poll(make_poll(16'd3,  0, 0, 0, 7'd0));
      send_poll(make_poll(16'd4,  0, 0, 0, 7'd0));
      send_poll(make_poll(16'd5,  0, 1, 0, 7'd0));    // limit ends calibration
      send_poll(make_poll(16'd6,  0, 0, 0, 7'd0));    // held command -> move-to
      send_poll(make_poll(16'd7,  0, 0, 0, 7'd0));    // target equals position
      send_poll(make_poll(16'd8,  1, 0, 0, 7'd0));    // stale low bits -> move-to
      send_poll(make_poll(16'd9,  0, 0, 0, 7'd0));    // falls back to idle-open
      send_poll(make_poll(16'd10, 1, 0, 0, 7'd0));    // open from position zero
      send_poll(make_poll(16'd11, 0, 0, 0, 7'd0));    // position wraps below zero
      send_poll(make_poll(16'd12, 0, 0, 0, 7'd0));
      send_poll(make_poll(16'd13, 1, 0, 0, 7'd0));    // click stops open
      send_poll(make_poll(16'd14, 1, 0, 0, 7'd0));    // close stops at once
      send_poll(make_poll(16'd15, 0, 0, 1, 7'd127));  // percent above 100
      send_poll(make_poll(16'd16, 0, 0, 0, 7'd0));    // zero target -> open
      send_poll(make_poll(16'd17, 0, 0, 0, 7'd0));    // zero target forces calibration
      send_poll(make_poll(16'd18, 1, 1, 0, 7'd0));    // start and finish together
      send_poll(make_poll(16'd19, 0, 0, 1, 7'd127));
      send_poll(make_poll(16'd20, 0, 0, 0, 7'd0));    // product wraps, close
      send_poll(make_poll(16'd21, 0, 0, 0, 7'd0));
      send_poll(make_poll(16'd21, 0, 0, 0, 7'd0));    // delay not yet passed
      send_poll(make_poll(16'hFFFF, 0, 0, 1, 7'd0));  // new command stops close
      send_poll(make_poll(16'd0,  0, 0, 0, 7'd0));
      send_poll(make_poll(16'd1,  0, 0, 0, 7'd0));
   endtask

   task automatic test_fast_stepping();
      configure(16'd0, $urandom);
      gap_pct   = 10;
      stall_pct = 5;
      run_random_polls(130);
   endtask

   task automatic test_slow_stepping();
      configure(16'hFFFF, 32'h0000_0000);
      gap_pct   = 0;
      stall_pct = 8;
      run_random_polls(120);
   endtask

   task automatic test_coil_table_extremes();
      configure(16'd1, 32'hFFFF_FFFF);
      gap_pct   = 8;
      stall_pct = 0;
      run_random_polls(130);
   endtask

   task automatic test_mixed_timing();
      configure(16'($urandom_range(1, 6)), $urandom);
      gap_pct   = 12;
      stall_pct = 12;
      run_random_polls(130);
   endtask

   task automatic test_back_to_back();
      configure(sbpc_pkg::STEP_DELAY_RESET, sbpc_pkg::PHASE_TABLE_RESET);
      gap_pct   = 0;
      stall_pct = 0;
      run_random_polls(120);
   endtask

   // Status channel ready: held low in random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_bus.ready <= 1'b0;
         stall_left = $urandom_range(0, 18);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Compare every status beat against the oldest prediction
   always @(posedge clock) begin : check_status
      status_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (due_status.size() == 0) begin
            $error("status beat with nothing predicted: position %0h", rsp_bus.position);
            mismatches++;
         end else begin
            want = due_status.pop_front();
            if (rsp_bus.coil_drive !== want.coil_drive) begin
               $error("coil_drive: expected %0h, got %0h", want.coil_drive, rsp_bus.coil_drive);
               mismatches++;
            end
            if (rsp_bus.position !== want.position) begin
               $error("position: expected %0h, got %0h", want.position, rsp_bus.position);
               mismatches++;
            end
            if (rsp_bus.report_valid !== want.report_valid) begin
               $error("report_valid: expected %0b, got %0b",
                      want.report_valid, rsp_bus.report_valid);
               mismatches++;
            end
            if (rsp_bus.mode !== want.mode) begin
               $error("mode: expected %0d, got %0d", want.mode, rsp_bus.mode);
               mismatches++;
            end
         end
      end
   end

   initial begin
      reset                   <= 1'b1;
      req_bus.valid           <= 1'b0;
      req_bus.now_ticks       <= '0;
      req_bus.click           <= 1'b0;
      req_bus.limit_hit       <= 1'b0;
      req_bus.command_valid   <= 1'b0;
      req_bus.command_percent <= '0;
      csr_psel                <= 1'b0;
      csr_penable             <= 1'b0;
      csr_pwrite              <= 1'b0;
      csr_paddr               <= '0;
      csr_pwdata              <= '0;
      gap_pct   = 0;
      stall_pct = 0;
      reset_blind();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_corners();
      test_fast_stepping();
      test_slow_stepping();
      test_coil_table_extremes();
      test_mixed_timing();
      test_back_to_back();

      // Drain and let the pipeline settle
      req_bus.valid <= 1'b0;
      while (due_status.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: files.f
hdl/sbpc_pkg.sv
hdl/sbpc_req_if.sv
hdl/sbpc_rsp_if.sv
hdl/stepper_blind_position_controller.sv
tb/tb_stepper_blind_position_controller.sv
